// File: rtl/palette_delta_decoder_top_macros.svh
`ifndef PALETTE_DELTA_DECODER_TOP_MACROS_SVH
`define PALETTE_DELTA_DECODER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pdd_pkg.sv
package pdd_pkg;

    // Field widths of one transfer
    localparam int BYTE_W   = 8;
    localparam int FILLED_W = 9;
    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 6;
    localparam int STATUS_W = 2;

    // Packed stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = M_TDATA_W - FILLED_W - COLOR_W;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RDATA,
        ST_RUN_RD,
        ST_RUN_WR,
        ST_FINISH,
        ST_TAIL_RD,
        ST_TAIL_WR,
        ST_SWAP,
        ST_RESULT
    } state_t;

    // Chunk parser phase
    typedef enum logic [1:0] {
        PH_CMD,
        PH_GREEN,
        PH_BLUE,
        PH_OFFSET
    } phase_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RES_BYTE   = 2'd0,
        RES_COMMIT = 2'd1,
        RES_ERROR  = 2'd2,
        RES_READ   = 2'd3
    } result_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic apply_byte;
        logic start_read;
        logic capture_read;
        logic capture_result;
        logic start_tail;
        logic copy_rd;
        logic copy_wr;
        logic swap;
        logic end_chunk;
        logic load_out;
    } pdd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic func;
        logic last;
        logic error;
        logic run_go;
        logic tail_empty;
        logic copy_last;
        logic out_free;
    } pdd_sts_t;

    // Widen a 6-bit colour component to 8 bits
    function automatic logic [BYTE_W-1:0] expand6(input logic [CHAN_W-1:0] v);
        return {v, v[CHAN_W-1:CHAN_W-2]};
    endfunction

endpackage

// File: rtl/palette_delta_decoder_top.sv
// A literal byte or a held byte walks DECODE, FINISH and RESULT before m_axis_tvalid rises; a read
// walks DECODE, RDATA and RESULT. A copy run adds a RUN_RD and RUN_WR step per entry; a commit adds
// SWAP plus a TAIL_RD and TAIL_WR step per entry not written. One item at a time: the next is taken
// only when the controller walk is back in IDLE. Reset: rst_n clears control state at once, then a
// clearing pass zeroes both banks with s_axis_tready low.
`include "palette_delta_decoder_top_macros.svh"

module palette_delta_decoder_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pdd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // data_byte[7:0], read_index[15:8]
    input  logic                            s_axis_tlast,  // chunk_end
    input  logic [0:0]                      s_axis_tuser,  // func[0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pdd_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // entries_filled[8:0], read_color[32:9]
    output logic [pdd_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status[1:0]
);

    pdd_pkg::pdd_cmd_t              ctrl_cmd;
    pdd_pkg::pdd_sts_t              ctrl_sts;
    logic [pdd_pkg::STATUS_W-1:0]   out_status;
    logic [pdd_pkg::FILLED_W-1:0]   out_filled;
    logic [pdd_pkg::COLOR_W-1:0]    out_color;

    pdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (ctrl_sts),
        .cmd      (ctrl_cmd)
    );

    pdd_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .sts        (ctrl_sts),
        .in_func    (s_axis_tuser[0]),
        .in_byte    (s_axis_tdata[7:0]),
        .in_last    (s_axis_tlast),
        .in_ridx    (s_axis_tdata[15:8]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_filled (out_filled),
        .out_color  (out_color)
    );

    // Pack the result transfer
    assign m_axis_tdata = {{pdd_pkg::M_PAD_W{1'b0}}, out_color, out_filled};
    assign m_axis_tuser = out_status;

    `PDD_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while another is in work")
    `PDD_ASSERT_SAME(a_no_overwrite, ctrl_cmd.load_out, ctrl_sts.out_free, "result loaded over a pending transfer")
    `PDD_ASSERT_SAME(a_color_on_read, m_axis_tvalid && (m_axis_tuser != pdd_pkg::RES_READ), m_axis_tdata[32:9] == 24'd0, "colour set on a non-read result")
    `PDD_ASSERT_SAME(a_fill_bound, m_axis_tvalid, m_axis_tdata[8:0] <= 9'(PALETTE_ENTRIES), "fill count beyond palette size")

endmodule

// File: rtl/pdd_ctrl.sv
module pdd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdd_pkg::pdd_sts_t sts,
    output pdd_pkg::pdd_cmd_t cmd
);

    pdd_pkg::state_t state_reg;
    pdd_pkg::state_t state_next;

    // State register; clearing pass runs first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdd_pkg::ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = pdd_pkg::ST_IDLE;
            end
            pdd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pdd_pkg::ST_DECODE;
            end
            pdd_pkg::ST_DECODE:
            begin
                if (sts.func)
                    state_next = pdd_pkg::ST_RDATA;
                else if (sts.run_go)
                    state_next = pdd_pkg::ST_RUN_RD;
                else
                    state_next = pdd_pkg::ST_FINISH;
            end
            pdd_pkg::ST_RDATA:
            begin
                state_next = pdd_pkg::ST_RESULT;
            end
            pdd_pkg::ST_RUN_RD:
            begin
                state_next = pdd_pkg::ST_RUN_WR;
            end
            pdd_pkg::ST_RUN_WR:
            begin
                state_next = sts.copy_last ? pdd_pkg::ST_FINISH : pdd_pkg::ST_RUN_RD;
            end
            pdd_pkg::ST_FINISH:
            begin
                if (!sts.last || sts.error)
                    state_next = pdd_pkg::ST_RESULT;
                else if (sts.tail_empty)
                    state_next = pdd_pkg::ST_SWAP;
                else
                    state_next = pdd_pkg::ST_TAIL_RD;
            end
            pdd_pkg::ST_TAIL_RD:
            begin
                state_next = pdd_pkg::ST_TAIL_WR;
            end
            pdd_pkg::ST_TAIL_WR:
            begin
                state_next = sts.copy_last ? pdd_pkg::ST_SWAP : pdd_pkg::ST_TAIL_RD;
            end
            pdd_pkg::ST_SWAP:
            begin
                state_next = pdd_pkg::ST_RESULT;
            end
            pdd_pkg::ST_RESULT:
            begin
                if (sts.out_free)
                    state_next = pdd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            pdd_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            pdd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            pdd_pkg::ST_DECODE:
            begin
                cmd.start_read = sts.func;
                cmd.apply_byte = !sts.func;
            end
            pdd_pkg::ST_RDATA:
            begin
                cmd.capture_read = 1'b1;
            end
            pdd_pkg::ST_RUN_RD,
            pdd_pkg::ST_TAIL_RD:
            begin
                cmd.copy_rd = 1'b1;
            end
            pdd_pkg::ST_RUN_WR,
            pdd_pkg::ST_TAIL_WR:
            begin
                cmd.copy_wr = 1'b1;
            end
            pdd_pkg::ST_FINISH:
            begin
                cmd.capture_result = 1'b1;
                cmd.end_chunk      = sts.last && sts.error;
                cmd.start_tail     = sts.last && !sts.error && !sts.tail_empty;
            end
            pdd_pkg::ST_SWAP:
            begin
                cmd.swap      = 1'b1;
                cmd.end_chunk = 1'b1;
            end
            pdd_pkg::ST_RESULT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/pdd_datapath.sv
module pdd_datapath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pdd_pkg::pdd_cmd_t               cmd,
    output pdd_pkg::pdd_sts_t               sts,
    input  logic                            in_func,
    input  logic [pdd_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            in_last,
    input  logic [pdd_pkg::BYTE_W-1:0]      in_ridx,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pdd_pkg::STATUS_W-1:0]    out_status,
    output logic [pdd_pkg::FILLED_W-1:0]    out_filled,
    output logic [pdd_pkg::COLOR_W-1:0]     out_color
);

    localparam int DEPTH  = 2 * PALETTE_ENTRIES;
    localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
    localparam int FILL_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = 10;

    // Item registers
    logic                          item_func_reg;
    logic [pdd_pkg::BYTE_W-1:0]    item_byte_reg;
    logic                          item_last_reg;
    logic [pdd_pkg::BYTE_W-1:0]    item_ridx_reg;

    // Chunk parser state
    logic                          bank_reg;
    logic [FILL_W-1:0]             fill_reg;
    pdd_pkg::phase_t               phase_reg;
    logic [pdd_pkg::CHAN_W-1:0]    held_count_reg;
    logic [pdd_pkg::CHAN_W-1:0]    held_red_reg;
    logic [pdd_pkg::CHAN_W-1:0]    held_green_reg;
    logic                          error_reg;

    // Copy walker
    logic [IDX_W-1:0]              src_reg;
    logic [IDX_W-1:0]              dst_reg;
    logic [FILL_W-1:0]             rem_reg;
    logic [ADDR_W-1:0]             clr_reg;

    // Palette store
    logic [pdd_pkg::COLOR_W-1:0]   mem [DEPTH];
    logic [pdd_pkg::COLOR_W-1:0]   rd_data_reg;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [pdd_pkg::COLOR_W-1:0]   wr_data;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;

    // Pending result and output register
    logic [pdd_pkg::STATUS_W-1:0]  res_status_reg;
    logic [pdd_pkg::FILLED_W-1:0]  res_filled_reg;
    logic [pdd_pkg::COLOR_W-1:0]   res_color_reg;
    logic                          m_valid_reg;
    logic [pdd_pkg::STATUS_W-1:0]  m_status_reg;
    logic [pdd_pkg::FILLED_W-1:0]  m_filled_reg;
    logic [pdd_pkg::COLOR_W-1:0]   m_color_reg;

    // Byte decode
    logic                          ignore_c;
    logic                          run_req_c;
    logic [pdd_pkg::BYTE_W-1:0]    run_src_c;
    logic [pdd_pkg::BYTE_W-1:0]    run_n_c;
    logic [SUM_W-1:0]              run_dst_end_c;
    logic [SUM_W-1:0]              run_src_end_c;
    logic                          run_over_c;
    logic                          run_go_c;
    logic                          ridx_ok_c;
    logic                          literal_c;

    function automatic logic [ADDR_W-1:0] addr_of(input logic bank, input logic [IDX_W-1:0] idx);
        return bank ? (ADDR_W'(PALETTE_ENTRIES) + ADDR_W'(idx)) : ADDR_W'(idx);
    endfunction

    // Decode the held byte against the parser state
    always_comb
    begin
        ignore_c  = error_reg || (fill_reg == FILL_W'(PALETTE_ENTRIES));
        run_req_c = 1'b0;
        run_src_c = pdd_pkg::BYTE_W'(fill_reg);
        run_n_c   = {1'b0, item_byte_reg[6:0]} + 8'd1;
        if (phase_reg == pdd_pkg::PH_CMD && item_byte_reg[7])
        begin
            run_req_c = 1'b1;
        end
        else if (phase_reg == pdd_pkg::PH_OFFSET)
        begin
            run_req_c = 1'b1;
            run_src_c = item_byte_reg;
            run_n_c   = {2'b00, held_count_reg} + 8'd1;
        end
        run_dst_end_c = SUM_W'(fill_reg) + SUM_W'(run_n_c);
        run_src_end_c = SUM_W'(run_src_c) + SUM_W'(run_n_c);
        run_over_c    = (run_dst_end_c > SUM_W'(PALETTE_ENTRIES))
                     || (run_src_end_c > SUM_W'(PALETTE_ENTRIES));
        run_go_c      = !ignore_c && run_req_c && !run_over_c;
        literal_c     = !ignore_c && (phase_reg == pdd_pkg::PH_BLUE);
        ridx_ok_c     = {1'b0, item_ridx_reg} < 9'(PALETTE_ENTRIES);
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_func_reg <= in_func;
            item_byte_reg <= in_byte;
            item_last_reg <= in_last;
            item_ridx_reg <= in_ridx;
        end
    end

    // Parser state and bank select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg       <= 1'b0;
            fill_reg       <= '0;
            phase_reg      <= pdd_pkg::PH_CMD;
            held_count_reg <= '0;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            error_reg      <= 1'b0;
        end
        else if (cmd.end_chunk)
        begin
            bank_reg       <= bank_reg ^ cmd.swap;
            fill_reg       <= '0;
            phase_reg      <= pdd_pkg::PH_CMD;
            held_count_reg <= '0;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            error_reg      <= 1'b0;
        end
        else if (cmd.apply_byte && !ignore_c)
        begin
            case (phase_reg)
                pdd_pkg::PH_CMD:
                begin
                    if (item_byte_reg[7])
                    begin
                        if (run_over_c)
                            error_reg <= 1'b1;
                        else
                            fill_reg <= run_dst_end_c[FILL_W-1:0];
                    end
                    else if (item_byte_reg[6])
                    begin
                        held_count_reg <= item_byte_reg[5:0];
                        phase_reg      <= pdd_pkg::PH_OFFSET;
                    end
                    else
                    begin
                        held_red_reg <= item_byte_reg[5:0];
                        phase_reg    <= pdd_pkg::PH_GREEN;
                    end
                end
                pdd_pkg::PH_GREEN:
                begin
                    held_green_reg <= item_byte_reg[5:0];
                    phase_reg      <= pdd_pkg::PH_BLUE;
                end
                pdd_pkg::PH_BLUE:
                begin
                    fill_reg  <= fill_reg + FILL_W'(1);
                    phase_reg <= pdd_pkg::PH_CMD;
                end
                pdd_pkg::PH_OFFSET:
                begin
                    phase_reg <= pdd_pkg::PH_CMD;
                    if (run_over_c)
                        error_reg <= 1'b1;
                    else
                        fill_reg <= run_dst_end_c[FILL_W-1:0];
                end
                default:
                begin
                    phase_reg <= pdd_pkg::PH_CMD;
                end
            endcase
        end
    end

    // Copy walker: set up a run or the tail, then advance per entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            dst_reg <= '0;
            rem_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.apply_byte && run_go_c)
            begin
                src_reg <= run_src_c[IDX_W-1:0];
                dst_reg <= fill_reg[IDX_W-1:0];
                rem_reg <= FILL_W'(run_n_c);
            end
            else if (cmd.start_tail)
            begin
                src_reg <= fill_reg[IDX_W-1:0];
                dst_reg <= fill_reg[IDX_W-1:0];
                rem_reg <= FILL_W'(PALETTE_ENTRIES) - fill_reg;
            end
            else if (cmd.copy_wr)
            begin
                src_reg <= src_reg + IDX_W'(1);
                dst_reg <= dst_reg + IDX_W'(1);
                rem_reg <= rem_reg - FILL_W'(1);
            end
            if (cmd.clear_step)
                clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    // Store ports: clear, literal or copy write; request or copy read
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.apply_byte && literal_c)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_of(!bank_reg, fill_reg[IDX_W-1:0]);
            wr_data = {pdd_pkg::expand6(held_red_reg), pdd_pkg::expand6(held_green_reg),
                       pdd_pkg::expand6(item_byte_reg[5:0])};
        end
        else if (cmd.copy_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_of(!bank_reg, dst_reg);
            wr_data = rd_data_reg;
        end

        rd_en   = cmd.start_read || cmd.copy_rd;
        rd_addr = addr_of(bank_reg, src_reg);
        if (cmd.start_read)
            rd_addr = addr_of(bank_reg, ridx_ok_c ? item_ridx_reg[IDX_W-1:0] : '0);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Capture the result of the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture_read)
        begin
            res_status_reg <= pdd_pkg::RES_READ;
            res_filled_reg <= pdd_pkg::FILLED_W'(fill_reg);
            res_color_reg  <= ridx_ok_c ? rd_data_reg : '0;
        end
        else if (cmd.capture_result)
        begin
            if (item_last_reg && !error_reg)
                res_status_reg <= pdd_pkg::RES_COMMIT;
            else if (error_reg)
                res_status_reg <= pdd_pkg::RES_ERROR;
            else
                res_status_reg <= pdd_pkg::RES_BYTE;
            res_filled_reg <= pdd_pkg::FILLED_W'(fill_reg);
            res_color_reg  <= '0;
        end
    end

    // Output register; drop valid once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_status_reg <= res_status_reg;
            m_filled_reg <= res_filled_reg;
            m_color_reg  <= res_color_reg;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_filled = m_filled_reg;
    assign out_color  = m_color_reg;

    // Status to the controller
    always_comb
    begin
        sts.clear_done = (clr_reg == ADDR_W'(DEPTH - 1));
        sts.func       = item_func_reg;
        sts.last       = item_last_reg;
        sts.error      = error_reg;
        sts.run_go     = run_go_c;
        sts.tail_empty = (fill_reg == FILL_W'(PALETTE_ENTRIES));
        sts.copy_last  = (rem_reg == FILL_W'(1));
        sts.out_free   = !m_valid_reg || out_ready;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ENTRIES = 256;

    // One chunk byte or palette read, and the result it gives
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       chunk_end;
        logic [7:0] read_index;
    } chunk_item_t;

    typedef struct packed {
        pdd_pkg::result_t status;
        logic [8:0]       entries_filled;
        logic [23:0]      read_color;
    } decode_result_t;

    typedef struct packed {
        chunk_item_t    item;
        logic           typed;
        decode_result_t want;
    } directed_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [pdd_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          s_axis_tlast;
    logic [0:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [pdd_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [pdd_pkg::M_TUSER_W-1:0] m_axis_tuser;

    // Shadow palette and parser state
    logic [23:0]      bank_mem [0:2*ENTRIES-1];
    logic             live_bank  = 1'b0;
    logic [8:0]       next_slot  = '0;
    pdd_pkg::phase_t  parse_ph   = pdd_pkg::PH_CMD;
    logic [6:0]       run_len    = '0;
    logic [5:0]       red_part   = '0;
    logic [5:0]       green_part = '0;
    logic             run_fault  = 1'b0;

    // Item on the slave side and its typed expectation, if any
    chunk_item_t    cur_item;
    logic           cur_typed = 1'b0;
    decode_result_t cur_want;
    logic           steady = 1'b0;

    decode_result_t pending_results [$];
    directed_row_t  directed_rows [$];
    chunk_item_t    random_items [$];
    int             fault_count = 0;

    palette_delta_decoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Widen a 6-bit component: shift up two and refill from the top bits
    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Copy n entries of the committed palette into the new one
    function automatic void copy_entries(input int src, input int n);
        int i;
        int old_b;
        int new_b;
        old_b = live_bank ? ENTRIES : 0;
        new_b = live_bank ? 0 : ENTRIES;
        if (next_slot + n > ENTRIES || src + n > ENTRIES)
        begin
            run_fault = 1'b1;
            return;
        end
        for (i = 0; i < n; i++)
            bank_mem[new_b + next_slot + i] = bank_mem[old_b + src + i];
        next_slot = next_slot + n;
    endfunction

    // Advance the chunk parser by one byte
    function automatic void parse_chunk_byte(input logic [7:0] b);
        int new_b;
        new_b = live_bank ? 0 : ENTRIES;
        if (run_fault || next_slot >= ENTRIES)
            return;
        case (parse_ph)
            pdd_pkg::PH_CMD:
            begin
                if (b[7])
                    copy_entries(next_slot, 1 + b[6:0]);
                else if (b[6])
                begin
                    run_len  = {1'b0, b[5:0]};
                    parse_ph = pdd_pkg::PH_OFFSET;
                end
                else
                begin
                    red_part = b[5:0];
                    parse_ph = pdd_pkg::PH_GREEN;
                end
            end
            pdd_pkg::PH_GREEN:
            begin
                green_part = b[5:0];
                parse_ph   = pdd_pkg::PH_BLUE;
            end
            pdd_pkg::PH_BLUE:
            begin
                bank_mem[new_b + next_slot] =
                    {widen6(red_part), widen6(green_part), widen6(b[5:0])};
                next_slot = next_slot + 1;
                parse_ph  = pdd_pkg::PH_CMD;
            end
            default:
            begin
                parse_ph = pdd_pkg::PH_CMD;
                copy_entries(b, run_len + 1);
            end
        endcase
    endfunction

    // Work out the result of one accepted item and update the shadow state
    function automatic decode_result_t decode_item(input chunk_item_t it);
        decode_result_t r;
        int old_b;
        int new_b;
        int i;
        old_b = live_bank ? ENTRIES : 0;
        new_b = live_bank ? 0 : ENTRIES;
        r.read_color = '0;
        if (it.func)
        begin
            r.status         = pdd_pkg::RES_READ;
            r.entries_filled = next_slot;
            r.read_color     = bank_mem[old_b + it.read_index];
            return r;
        end
        parse_chunk_byte(it.data_byte);
        r.entries_filled = next_slot;
        r.status         = run_fault ? pdd_pkg::RES_ERROR : pdd_pkg::RES_BYTE;
        if (it.chunk_end)
        begin
            // Commit: fill the rest from the old palette and swap banks
            if (!run_fault)
            begin
                for (i = next_slot; i < ENTRIES; i++)
                    bank_mem[new_b + i] = bank_mem[old_b + i];
                live_bank = ~live_bank;
                r.status  = pdd_pkg::RES_COMMIT;
            end
            next_slot  = '0;
            parse_ph   = pdd_pkg::PH_CMD;
            run_len    = '0;
            red_part   = '0;
            green_part = '0;
            run_fault  = 1'b0;
        end
        return r;
    endfunction

    task automatic add_row(input logic f, input logic [7:0] b, input logic e,
                           input logic [7:0] ri, input logic typed,
                           input pdd_pkg::result_t st,
                           input logic [8:0] fl, input logic [23:0] col);
        directed_row_t row;
        row.item  = '{f, b, e, ri};
        row.typed = typed;
        row.want  = '{st, fl, col};
        directed_rows.push_back(row);
    endtask

    function automatic void push_byte(input logic [7:0] b);
        chunk_item_t it;
        it = '{1'b0, b, 1'b0, 8'($urandom)};
        random_items.push_back(it);
    endfunction

    function automatic void push_read();
        chunk_item_t it;
        it = '{1'b1, 8'($urandom), 1'($urandom), 8'($urandom)};
        random_items.push_back(it);
    endfunction

    // Build one chunk: mostly well-formed commands, some noise
    function automatic void build_chunk();
        int n_cmds;
        int k;
        int fill;
        int room;
        int cap;
        int cnt;
        int off;
        int pick;
        logic wild;
        if ($urandom_range(6) == 0)
        begin
            n_cmds = $urandom_range(1, 15);
            for (k = 0; k < n_cmds; k++)
            begin
                if ($urandom_range(7) == 0)
                    push_read();
                push_byte(8'($urandom));
                if ($urandom_range(7) == 0)
                    random_items[random_items.size() - 1].chunk_end = 1'b1;
            end
        end
        else
        begin
            fill = 0;
            // Sometimes fill the whole palette up front
            if ($urandom_range(9) == 0)
            begin
                push_byte(8'hFF);
                push_byte(8'hFF);
                fill = ENTRIES;
            end
            n_cmds = ($urandom_range(7) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 8);
            for (k = 0; k < n_cmds; k++)
            begin
                if ($urandom_range(9) == 0)
                    push_read();
                room = (fill < ENTRIES) ? ENTRIES - fill : 128;
                wild = ($urandom_range(19) == 0);
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    push_byte({2'b00, 6'($urandom)});
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                    fill = fill + 1;
                end
                else if (pick < 70)
                begin
                    cap = (room < 128) ? room : 128;
                    cnt = wild ? $urandom_range(1, 128)
                               : $urandom_range(1, $urandom_range(1, cap));
                    push_byte({1'b1, 7'(cnt - 1)});
                    fill = fill + cnt;
                end
                else
                begin
                    cap = (room < 64) ? room : 64;
                    cnt = wild ? $urandom_range(1, 64)
                               : $urandom_range(1, $urandom_range(1, cap));
                    off = wild ? $urandom_range(0, 255) : $urandom_range(0, ENTRIES - cnt);
                    push_byte({2'b01, 6'(cnt - 1)});
                    push_byte(8'(off));
                    fill = fill + cnt;
                end
            end
            // Cut the last command short now and then
            if ($urandom_range(5) == 0)
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                    push_byte({2'b01, 6'($urandom)});
                else
                begin
                    push_byte({2'b00, 6'($urandom)});
                    if (pick == 2)
                        push_byte(8'($urandom));
                end
            end
        end
        random_items[random_items.size() - 1].chunk_end = 1'b1;
    endfunction

    // Present one item, hold it until the transfer, then move to the falling edge
    task automatic send_item(input chunk_item_t it, input logic typed,
                             input decode_result_t want);
        if (!steady && $urandom_range(99) < 10)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        cur_item      = it;
        cur_typed     = typed;
        cur_want      = want;
        s_axis_tdata  = {it.read_index, it.data_byte};
        s_axis_tlast  = it.chunk_end;
        s_axis_tuser  = it.func;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Master side back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = steady || ($urandom_range(99) >= 10);
        end
    end

    // Predict on each slave transfer, check on each master transfer
    always @(posedge clk)
    begin : scoreboard
        decode_result_t want;
        logic [8:0]     got_filled;
        logic [23:0]    got_color;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = decode_item(cur_item);
                if (cur_typed)
                    want = cur_want;
                pending_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_filled = m_axis_tdata[8:0];
                got_color  = m_axis_tdata[32:9];
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d", m_axis_tuser);
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fault_count++;
                    end
                    if (got_filled !== want.entries_filled)
                    begin
                        $error("entries_filled: expected %0d, got %0d",
                               want.entries_filled, got_filled);
                        fault_count++;
                    end
                    if (got_color !== want.read_color)
                    begin
                        $error("read_color: expected %06h, got %06h", want.read_color, got_color);
                        fault_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        decode_result_t none;
        none          = '{pdd_pkg::RES_BYTE, 9'd0, 24'd0};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        cur_item      = '0;
        cur_want      = none;
        foreach (bank_mem[k])
            bank_mem[k] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reads after reset, extreme indexes
        add_row(1'b1, 8'h00, 1'b0, 8'd0,   1'b1, pdd_pkg::RES_READ, 9'd0, 24'h000000);
        add_row(1'b1, 8'hFF, 1'b1, 8'd255, 1'b1, pdd_pkg::RES_READ, 9'd0, 24'h000000);
        // Literal at full scale, then at zero
        add_row(1'b0, 8'h3F, 1'b0, 8'hFF, 1'b1, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'hFF, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'hFF, 1'b0, 8'hA5, 1'b1, pdd_pkg::RES_BYTE, 9'd1, 24'h000000);
        add_row(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd2, 24'h000000);
        add_row(1'b0, 8'h15, 1'b0, 8'h3C, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h6A, 1'b0, 8'hC3, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h81, 1'b0, 8'h0F, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        // Read in the middle of a chunk ignores chunk_end
        add_row(1'b1, 8'h5A, 1'b1, 8'd3,  1'b1, pdd_pkg::RES_READ, 9'd3, 24'h000000);
        // Same-position copy, then offset copy
        add_row(1'b0, 8'h80, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h41, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        // Truncated literal dropped at commit
        add_row(1'b0, 8'h3F, 1'b0, 8'h00, 1'b0, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'h20, 1'b1, 8'h00, 1'b1, pdd_pkg::RES_COMMIT, 9'd6, 24'h000000);
        add_row(1'b1, 8'h00, 1'b0, 8'd0,  1'b1, pdd_pkg::RES_READ, 9'd0, 24'hFFFFFF);
        // Fill the palette with two maximum runs, then a byte that is ignored
        add_row(1'b0, 8'hFF, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd128, 24'h000000);
        add_row(1'b0, 8'hFF, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd256, 24'h000000);
        add_row(1'b0, 8'h3F, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd256, 24'h000000);
        add_row(1'b0, 8'h00, 1'b1, 8'h00, 1'b1, pdd_pkg::RES_COMMIT, 9'd256, 24'h000000);
        // Offset run past the end keeps the old palette
        add_row(1'b0, 8'h7F, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_BYTE, 9'd0, 24'h000000);
        add_row(1'b0, 8'hFF, 1'b0, 8'h00, 1'b1, pdd_pkg::RES_ERROR, 9'd0, 24'h000000);
        add_row(1'b0, 8'h00, 1'b1, 8'h00, 1'b1, pdd_pkg::RES_ERROR, 9'd0, 24'h000000);
        add_row(1'b1, 8'h00, 1'b0, 8'd0,  1'b1, pdd_pkg::RES_READ, 9'd0, 24'hFFFFFF);

        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

        while (random_items.size() < 2000)
            build_chunk();

        // Random chunks, with a stretch of no idling on either side
        foreach (random_items[k])
        begin
            steady = (k >= 700 && k < 1000);
            send_item(random_items[k], 1'b0, none);
        end
        steady        = 1'b0;
        s_axis_tvalid = 1'b0;

        // Drain, then allow for a full copy and commit to finish
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);

        if (fault_count == 0)
            $display("** palette_delta_decoder_top: PASSED **");
        else
            $display("** palette_delta_decoder_top: FAILED **");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #80_000_000;
        $display("** palette_delta_decoder_top: FAILED **");
        $finish;
    end

endmodule
